FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/sfcs_pkg.sv
`timescale 1ns / 1ps

package sfcs_pkg;

	localparam int TIME_W  = 32;
	localparam int CYCLE_W = 24;
	localparam int QUO_W   = 16;
	localparam int STEP_W  = 6;

	// Configuration register indexes.
	localparam logic [2:0] REG_FRAME_DELAY  = 3'd0;
	localparam logic [2:0] REG_FRAMES_ROW0  = 3'd1;
	localparam logic [2:0] REG_FRAMES_ROW1  = 3'd2;
	localparam logic [2:0] REG_PHASE_OFFSET = 3'd3;
	localparam logic [2:0] REG_SHEET_WIDTH  = 3'd4;
	localparam logic [2:0] REG_SHEET_HEIGHT = 3'd5;
	localparam logic [2:0] REG_HAS_PICTURE  = 3'd6;

	// Quotient bits the divider walks for each job.
	localparam logic [STEP_W-1:0] MOD_STEPS   = 6'd32;
	localparam logic [STEP_W-1:0] FRAME_STEPS = 6'd8;
	localparam logic [STEP_W-1:0] WIDTH_STEPS = 6'd16;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MOD_GO,
		ST_MOD_RUN,
		ST_FRM_GO,
		ST_FRM_RUN,
		ST_WID_GO,
		ST_WID_RUN,
		ST_MUL
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [CYCLE_W-1:0]   divisor;
		logic [CYCLE_W-1:0]   rem_init;
		logic [TIME_W-1:0]    dividend;
		logic [STEP_W-1:0]    steps;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [CYCLE_W-1:0]   rem;
		logic [QUO_W-1:0]     quo;
	} div_rsp_t;

endpackage

FILE: rtl/core/sfcs_div.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfcs_div import sfcs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [CYCLE_W-1:0]  rem_q;
	logic [CYCLE_W-1:0]  dsr_q;
	logic [TIME_W-1:0]   dvd_q;
	logic [QUO_W-1:0]    quo_q;

	logic [CYCLE_W+1:0]  diff;
	logic                borrow;
	logic [CYCLE_W-1:0]  rem_next;

	// One restoring step: bring down the next dividend bit and try the subtract.
	always_comb begin
		diff     = {1'b0, rem_q, dvd_q[TIME_W-1]} - {2'b00, dsr_q};
		borrow   = diff[CYCLE_W+1];
		rem_next = borrow ? {rem_q[CYCLE_W-2:0], dvd_q[TIME_W-1]} : diff[CYCLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			dsr_q <= req.divisor;
			dvd_q <= req.dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ~borrow};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;
	assign rsp.quo  = quo_q;

	`ASSERT_IMP(a_no_restart, clk, arst_n, req.start, !busy_q, "divider started while busy")
	`ASSERT_NXT(a_last_step, clk, arst_n, busy_q && !req.start && cnt_q == STEP_W'(1), done_q && !busy_q, "divider did not finish after last step")

endmodule

FILE: rtl/core/sprite_frame_clip_select.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Direction  Handshake              Beat contents
// input     in         in_valid / in_stall    now_time, row_select, play_enable
// result    out        out_valid / out_stall  clip_x, clip_y, clip_width, clip_height,
//                                              frame_index
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Items are taken one at a time: the next item is accepted only after the last one has
// left the multiply step. Playing with a picture attached runs every divide; stopped
// playback skips the frame divide, no picture skips the width divide, and a zero frame
// delay skips the phase divide. All divides go through the shared restoring divider,
// which produces one quotient bit per cycle and walks 32 bits for the phase, 8 for the
// frame and 16 for the clip width. Reset restores the register defaults and clears the
// held clip origin. A stalled result blocks only the last step of the following item.

module sprite_frame_clip_select import sfcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] now_time,
	input  logic        row_select,
	input  logic        play_enable,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] clip_x,
	output logic [15:0] clip_y,
	output logic [15:0] clip_width,
	output logic [15:0] clip_height,
	output logic [7:0]  frame_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [15:0] delay_q;
	logic [7:0]  frames0_q;
	logic [7:0]  frames1_q;
	logic [31:0] offset_q;
	logic [15:0] sheet_w_q;
	logic [15:0] sheet_h_q;
	logic        has_pic_q;

	state_t state_q, state_d;

	logic [31:0]        now_q;
	logic               row_req_q;
	logic               play_q;
	logic [31:0]        sum_q;
	logic [CYCLE_W-1:0] cycle_q;
	logic               row_q;
	logic [CYCLE_W-1:0] phase_q;
	logic [7:0]         frame_q;
	logic [15:0]        cw_q;

	logic [23:0] held_x_q;
	logic [15:0] held_y_q;
	logic        out_valid_q;
	logic [15:0] cw_out_q;
	logic [15:0] ch_out_q;
	logic [7:0]  frame_out_q;

	logic [7:0]  f0;
	logic        two_rows;
	logic        row;
	logic [7:0]  fsel;
	logic [7:0]  fmax;
	logic [15:0] ch;
	logic [23:0] prod;
	logic        in_acc;
	logic        out_free;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q   <= '0;
			frames0_q <= 8'd1;
			frames1_q <= '0;
			offset_q  <= '0;
			sheet_w_q <= '0;
			sheet_h_q <= '0;
			has_pic_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_DELAY:  delay_q   <= cfg_data[15:0];
				REG_FRAMES_ROW0:  frames0_q <= cfg_data[7:0];
				REG_FRAMES_ROW1:  frames1_q <= cfg_data[7:0];
				REG_PHASE_OFFSET: offset_q  <= cfg_data;
				REG_SHEET_WIDTH:  sheet_w_q <= cfg_data[15:0];
				REG_SHEET_HEIGHT: sheet_h_q <= cfg_data[15:0];
				REG_HAS_PICTURE:  has_pic_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Row 0 always has at least one frame; row 1 counts only when it has frames.
	always_comb begin
		f0       = (frames0_q == 8'd0) ? 8'd1 : frames0_q;
		two_rows = (frames1_q != 8'd0);
		row      = row_req_q && two_rows;
		fsel     = row ? frames1_q : f0;
		fmax     = (f0 > frames1_q) ? f0 : frames1_q;
		if (!has_pic_q)
			ch = '0;
		else if (two_rows)
			ch = {1'b0, sheet_h_q[15:1]};
		else
			ch = sheet_h_q;
		prod = {8'd0, cw_q} * {16'd0, frame_q};
	end

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_PREP;
			ST_PREP:    state_d = ST_MOD_GO;
			ST_MOD_GO:  state_d = (cycle_q == '0) ? ST_FRM_GO : ST_MOD_RUN;
			ST_MOD_RUN: if (div_rsp.done) state_d = ST_FRM_GO;
			ST_FRM_GO:  state_d = (play_q && delay_q != '0) ? ST_FRM_RUN : ST_WID_GO;
			ST_FRM_RUN: if (div_rsp.done) state_d = ST_WID_GO;
			ST_WID_GO:  state_d = has_pic_q ? ST_WID_RUN : ST_MUL;
			ST_WID_RUN: if (div_rsp.done) state_d = ST_MUL;
			ST_MUL:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		div_req  = '0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_MOD_GO: begin
				div_req.start    = (cycle_q != '0);
				div_req.divisor  = cycle_q;
				div_req.dividend = sum_q;
				div_req.steps    = MOD_STEPS;
			end
			// The frame quotient stays below 256, so the upper phase bits
			// preload the remainder and only eight steps remain.
			ST_FRM_GO: begin
				div_req.start    = play_q && (delay_q != '0);
				div_req.divisor  = {8'd0, delay_q};
				div_req.rem_init = {8'd0, phase_q[23:8]};
				div_req.dividend = {phase_q[7:0], 24'd0};
				div_req.steps    = FRAME_STEPS;
			end
			ST_WID_GO: begin
				div_req.start    = has_pic_q;
				div_req.divisor  = {16'd0, fmax};
				div_req.dividend = {sheet_w_q, 16'd0};
				div_req.steps    = WIDTH_STEPS;
			end
			default: ;
		endcase
	end

	sfcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					now_q     <= now_time;
					row_req_q <= row_select;
					play_q    <= play_enable;
				end
			end
			ST_PREP: begin
				sum_q   <= now_q + offset_q;
				cycle_q <= {16'd0, fsel} * {8'd0, delay_q};
				row_q   <= row;
			end
			ST_MOD_GO:  if (cycle_q == '0) phase_q <= '0;
			ST_MOD_RUN: if (div_rsp.done) phase_q <= div_rsp.rem;
			ST_FRM_GO:  if (!play_q || delay_q == '0) frame_q <= '0;
			ST_FRM_RUN: if (div_rsp.done) frame_q <= div_rsp.quo[7:0];
			ST_WID_GO:  if (!has_pic_q) cw_q <= '0;
			ST_WID_RUN: if (div_rsp.done) cw_q <= div_rsp.quo;
			ST_MUL: begin
				if (out_free) begin
					cw_out_q    <= cw_q;
					ch_out_q    <= ch;
					frame_out_q <= frame_q;
				end
			end
			default: ;
		endcase
	end

	// The held origin doubles as the result's origin, so it moves only when a beat loads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q    <= '0;
			held_y_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_MUL && out_free) begin
				out_valid_q <= 1'b1;
				if (play_q) begin
					held_x_q <= prod;
					held_y_q <= row_q ? ch : 16'd0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign clip_x      = held_x_q;
	assign clip_y      = held_y_q;
	assign clip_width  = cw_out_q;
	assign clip_height = ch_out_q;
	assign frame_index = frame_out_q;

	`ASSERT_NXT(a_accept_prep, clk, arst_n, in_acc, state_q == ST_PREP, "accepted item did not enter prep")
	`ASSERT_IMP(a_phase_range, clk, arst_n, state_q == ST_MOD_RUN && div_rsp.done, div_rsp.rem < cycle_q, "phase not below cycle length")
	`ASSERT_IMP(a_frame_range, clk, arst_n, state_q == ST_FRM_RUN && div_rsp.done, div_rsp.quo[15:8] == 8'd0, "frame quotient overflowed eight bits")

endmodule
